// ----- sv/quaternion_product_rotate_unit_macros.svh -----
// ----------------------------------------------------------------------------
// quaternion product / rotate unit assertion macros
// shared concurrent assertion forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_PRODUCT_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_PRODUCT_ROTATE_UNIT_MACROS_SVH

// same-cycle implication
`define QPR_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/qpr_pkg.sv -----
// ----------------------------------------------------------------------------
// qpr_pkg
// shared types and constants of the quaternion product / rotate unit
// ----------------------------------------------------------------------------
package qpr_pkg;

  typedef enum logic [1:0] {
    MODE_PROD = 2'd0,
    MODE_ROT  = 2'd1,
    MODE_MAT  = 2'd2,
    MODE_RATE = 2'd3
  } qpr_mode_t;

  localparam int NUM_Q    = 4;
  localparam int NUM_PROD = 16;
  localparam int NUM_RES  = 9;
  localparam int NUM_VEC  = 3;
  localparam int PASS_STG = 4;

  // load enables of the four register stages of one pass
  typedef struct packed {
    logic mul1;
    logic mul2;
    logic sum;
    logic rnd;
  } qpr_stg_en_t;

  // position of product row r, column c in the 4x4 product grid
  function automatic logic [3:0] pidx(input logic [1:0] r, input logic [1:0] c);
    return {r, c};
  endfunction

endpackage

// ----- sv/qpr_mul.sv -----
// ----------------------------------------------------------------------------
// qpr_mul
// two-stage signed multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
module qpr_mul #(
  parameter int DW = 32
) (
  input  logic                   clk,
  input  logic                   en_mul,
  input  logic                   en_add,
  input  logic signed [DW-1:0]   x_i,
  input  logic signed [DW-1:0]   y_i,
  output logic signed [2*DW-1:0] prod_r
);

  localparam int LW = DW / 2;
  localparam int HW = DW - LW;

  logic signed [HW-1:0]    xh, yh;
  logic        [LW-1:0]    xl, yl;
  logic signed [2*HW-1:0]  hh_r;
  logic signed [HW+LW:0]   hl_r, lh_r;
  logic        [2*LW-1:0]  ll_r;
  logic        [2*DW-1:0]  phh, phl, plh, pll;

  assign xh = x_i[DW-1:LW];
  assign yh = y_i[DW-1:LW];
  assign xl = x_i[LW-1:0];
  assign yl = y_i[LW-1:0];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      hh_r <= xh * yh;
      hl_r <= xh * $signed({1'b0, yl});
      lh_r <= $signed({1'b0, xl}) * yh;
      ll_r <= xl * yl;
    end
  end

  // realign the partial products, sign extending the cross terms
  assign phh = {hh_r, {(2*LW){1'b0}}};
  assign phl = {{(HW-1){hl_r[HW+LW]}}, hl_r, {LW{1'b0}}};
  assign plh = {{(HW-1){lh_r[HW+LW]}}, lh_r, {LW{1'b0}}};
  assign pll = {{(2*HW){1'b0}}, ll_r};

  always_ff @(posedge clk) begin
    if (en_add) begin
      prod_r <= $signed(phh + phl + plh + pll);
    end
  end

endmodule

// ----- sv/qpr_round.sv -----
// ----------------------------------------------------------------------------
// qpr_round
// round-half-up and saturate a set of wide sums into data-width results
// ----------------------------------------------------------------------------
module qpr_round #(
  parameter int DW = 32,
  parameter int F  = 28,
  parameter int SW = 67,
  parameter int N  = 9
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 rate_i,
  input  logic signed [SW-1:0] sum_i [N],
  output logic signed [DW-1:0] res_r [N],
  output logic                 sat_r
);

  typedef logic signed [SW-1:0] acc_t;

  localparam acc_t HALF_F = acc_t'(1) << (F - 1);
  localparam acc_t HALF_R = acc_t'(1) << F;

  acc_t                 pre [N];
  acc_t                 shf [N];
  logic signed [DW-1:0] res_nxt [N];
  logic                 sat_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int k = 0; k < N; k++) begin
      pre[k] = sum_i[k] + (rate_i ? HALF_R : HALF_F);
      // rate terms carry one extra fraction bit for the factor one half
      shf[k] = rate_i ? (pre[k] >>> (F + 1)) : (pre[k] >>> F);
      if ((&shf[k][SW-1:DW-1]) || !(|shf[k][SW-1:DW-1])) begin
        res_nxt[k] = shf[k][DW-1:0];
      end else begin
        res_nxt[k] = shf[k][SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        sat_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

// ----- sv/qpr_pass_a.sv -----
// ----------------------------------------------------------------------------
// qpr_pass_a
// first pass: 4x4 product grid, per-mode sums, rounding of all nine elements
// ----------------------------------------------------------------------------
module qpr_pass_a #(
  parameter int DW = 32,
  parameter int F  = 28,
  parameter int SW = 67
) (
  input  logic                     clk,
  input  qpr_pkg::qpr_stg_en_t     en_i,
  input  qpr_pkg::qpr_mode_t       mode_i,
  input  logic signed [DW-1:0]     a_i [qpr_pkg::NUM_Q],
  input  logic signed [DW-1:0]     b_i [qpr_pkg::NUM_Q],
  output qpr_pkg::qpr_mode_t       mode_o,
  output logic signed [DW-1:0]     a_o [qpr_pkg::NUM_Q],
  output logic signed [DW-1:0]     res_o [qpr_pkg::NUM_RES],
  output logic                     sat_o
);

  import qpr_pkg::*;

  typedef logic signed [SW-1:0]   acc_t;
  typedef logic signed [2*DW-1:0] prod_t;

  localparam acc_t ONE = acc_t'(1) << (2 * F);

  logic signed [DW-1:0] opx [NUM_Q];
  logic signed [DW-1:0] opy [NUM_Q];
  prod_t                prod [NUM_PROD];
  acc_t                 ep [NUM_PROD];
  acc_t                 hq [NUM_Q];
  acc_t                 mat [NUM_RES];
  acc_t                 sum_nxt [NUM_RES];
  acc_t                 sum_r [NUM_RES];
  qpr_mode_t            mode1_r, mode2_r, mode3_r, mode4_r;
  logic signed [DW-1:0] a1_r [NUM_Q];
  logic signed [DW-1:0] a2_r [NUM_Q];
  logic signed [DW-1:0] a3_r [NUM_Q];
  logic signed [DW-1:0] a4_r [NUM_Q];

  // grid rows come from opx, columns from opy
  always_comb begin
    unique case (mode_i)
      MODE_PROD: begin
        opx = a_i;
        opy = b_i;
      end
      MODE_ROT: begin
        // pure quaternion of the vector times A
        opx[0] = '0;
        opx[1] = b_i[1];
        opx[2] = b_i[2];
        opx[3] = b_i[3];
        opy    = a_i;
      end
      MODE_MAT: begin
        opx = a_i;
        opy = a_i;
      end
      MODE_RATE: begin
        // A times the pure quaternion of omega
        opx    = a_i;
        opy[0] = '0;
        opy[1] = b_i[1];
        opy[2] = b_i[2];
        opy[3] = b_i[3];
      end
    endcase
  end

  for (genvar i = 0; i < NUM_Q; i++) begin : g_row
    for (genvar j = 0; j < NUM_Q; j++) begin : g_col
      qpr_mul #(.DW(DW)) u_mul (
        .clk    (clk),
        .en_mul (en_i.mul1),
        .en_add (en_i.mul2),
        .x_i    (opx[i]),
        .y_i    (opy[j]),
        .prod_r (prod[NUM_Q*i+j])
      );
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PROD; k++) begin
      ep[k] = acc_t'(prod[k]);
    end
  end

  // hamilton product components
  assign hq[0] = ep[pidx(2'd0, 2'd0)] - ep[pidx(2'd1, 2'd1)]
               - ep[pidx(2'd2, 2'd2)] - ep[pidx(2'd3, 2'd3)];
  assign hq[1] = ep[pidx(2'd0, 2'd1)] + ep[pidx(2'd1, 2'd0)]
               + ep[pidx(2'd2, 2'd3)] - ep[pidx(2'd3, 2'd2)];
  assign hq[2] = ep[pidx(2'd0, 2'd2)] + ep[pidx(2'd2, 2'd0)]
               + ep[pidx(2'd3, 2'd1)] - ep[pidx(2'd1, 2'd3)];
  assign hq[3] = ep[pidx(2'd0, 2'd3)] + ep[pidx(2'd3, 2'd0)]
               + ep[pidx(2'd1, 2'd2)] - ep[pidx(2'd2, 2'd1)];

  // rotation matrix: grid holds a_i * a_j, w is index zero
  assign mat[0] = ONE - ((ep[pidx(2'd2, 2'd2)] + ep[pidx(2'd3, 2'd3)]) <<< 1);
  assign mat[1] = (ep[pidx(2'd1, 2'd2)] - ep[pidx(2'd0, 2'd3)]) <<< 1;
  assign mat[2] = (ep[pidx(2'd1, 2'd3)] + ep[pidx(2'd0, 2'd2)]) <<< 1;
  assign mat[3] = (ep[pidx(2'd1, 2'd2)] + ep[pidx(2'd0, 2'd3)]) <<< 1;
  assign mat[4] = ONE - ((ep[pidx(2'd1, 2'd1)] + ep[pidx(2'd3, 2'd3)]) <<< 1);
  assign mat[5] = (ep[pidx(2'd2, 2'd3)] - ep[pidx(2'd0, 2'd1)]) <<< 1;
  assign mat[6] = (ep[pidx(2'd1, 2'd3)] - ep[pidx(2'd0, 2'd2)]) <<< 1;
  assign mat[7] = (ep[pidx(2'd2, 2'd3)] + ep[pidx(2'd0, 2'd1)]) <<< 1;
  assign mat[8] = ONE - ((ep[pidx(2'd1, 2'd1)] + ep[pidx(2'd2, 2'd2)]) <<< 1);

  always_comb begin
    if (mode2_r == MODE_MAT) begin
      sum_nxt = mat;
    end else begin
      for (int k = 0; k < NUM_RES; k++) begin
        sum_nxt[k] = '0;
      end
      for (int k = 0; k < NUM_Q; k++) begin
        sum_nxt[k] = hq[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i.mul1) begin
      mode1_r <= mode_i;
      a1_r    <= a_i;
    end
    if (en_i.mul2) begin
      mode2_r <= mode1_r;
      a2_r    <= a1_r;
    end
    if (en_i.sum) begin
      sum_r   <= sum_nxt;
      mode3_r <= mode2_r;
      a3_r    <= a2_r;
    end
    if (en_i.rnd) begin
      mode4_r <= mode3_r;
      a4_r    <= a3_r;
    end
  end

  qpr_round #(.DW(DW), .F(F), .SW(SW), .N(NUM_RES)) u_rnd (
    .clk    (clk),
    .en     (en_i.rnd),
    .rate_i (mode3_r == MODE_RATE),
    .sum_i  (sum_r),
    .res_r  (res_o),
    .sat_r  (sat_o)
  );

  assign mode_o = mode4_r;
  assign a_o    = a4_r;

endmodule

// ----- sv/qpr_pass_b.sv -----
// ----------------------------------------------------------------------------
// qpr_pass_b
// second pass: conj(A) times the first-pass quaternion, then result select
// ----------------------------------------------------------------------------
module qpr_pass_b #(
  parameter int DW = 32,
  parameter int F  = 28,
  parameter int SW = 67
) (
  input  logic                     clk,
  input  qpr_pkg::qpr_stg_en_t     en_i,
  input  qpr_pkg::qpr_mode_t       mode_i,
  input  logic signed [DW-1:0]     a_i [qpr_pkg::NUM_Q],
  input  logic signed [DW-1:0]     ra_i [qpr_pkg::NUM_RES],
  input  logic                     sa_i,
  output qpr_pkg::qpr_mode_t       mode_o,
  output logic signed [DW-1:0]     res_o [qpr_pkg::NUM_RES],
  output logic                     sat_o
);

  import qpr_pkg::*;

  typedef logic signed [SW-1:0]   acc_t;
  typedef logic signed [2*DW-1:0] prod_t;

  prod_t                prod [NUM_PROD];
  acc_t                 ep [NUM_PROD];
  acc_t                 sum_nxt [NUM_VEC];
  acc_t                 sum_r [NUM_VEC];
  logic signed [DW-1:0] rb [NUM_VEC];
  logic                 sb;
  qpr_mode_t            mode5_r, mode6_r, mode7_r, mode8_r;
  logic signed [DW-1:0] ra5_r [NUM_RES];
  logic signed [DW-1:0] ra6_r [NUM_RES];
  logic signed [DW-1:0] ra7_r [NUM_RES];
  logic signed [DW-1:0] ra8_r [NUM_RES];
  logic                 sa5_r, sa6_r, sa7_r, sa8_r;

  // only the off-diagonal products feed the vector part
  for (genvar i = 0; i < NUM_Q; i++) begin : g_row
    for (genvar j = 0; j < NUM_Q; j++) begin : g_col
      if (i != j) begin : g_mul
        qpr_mul #(.DW(DW)) u_mul (
          .clk    (clk),
          .en_mul (en_i.mul1),
          .en_add (en_i.mul2),
          .x_i    (a_i[i]),
          .y_i    (ra_i[j]),
          .prod_r (prod[NUM_Q*i+j])
        );
      end else begin : g_zero
        assign prod[NUM_Q*i+j] = '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PROD; k++) begin
      ep[k] = acc_t'(prod[k]);
    end
  end

  // vector part of conj(A) * t
  assign sum_nxt[0] = ep[pidx(2'd0, 2'd1)] - ep[pidx(2'd1, 2'd0)]
                    - ep[pidx(2'd2, 2'd3)] + ep[pidx(2'd3, 2'd2)];
  assign sum_nxt[1] = ep[pidx(2'd0, 2'd2)] - ep[pidx(2'd2, 2'd0)]
                    - ep[pidx(2'd3, 2'd1)] + ep[pidx(2'd1, 2'd3)];
  assign sum_nxt[2] = ep[pidx(2'd0, 2'd3)] - ep[pidx(2'd3, 2'd0)]
                    - ep[pidx(2'd1, 2'd2)] + ep[pidx(2'd2, 2'd1)];

  always_ff @(posedge clk) begin
    if (en_i.mul1) begin
      mode5_r <= mode_i;
      ra5_r   <= ra_i;
      sa5_r   <= sa_i;
    end
    if (en_i.mul2) begin
      mode6_r <= mode5_r;
      ra6_r   <= ra5_r;
      sa6_r   <= sa5_r;
    end
    if (en_i.sum) begin
      sum_r   <= sum_nxt;
      mode7_r <= mode6_r;
      ra7_r   <= ra6_r;
      sa7_r   <= sa6_r;
    end
    if (en_i.rnd) begin
      mode8_r <= mode7_r;
      ra8_r   <= ra7_r;
      sa8_r   <= sa7_r;
    end
  end

  qpr_round #(.DW(DW), .F(F), .SW(SW), .N(NUM_VEC)) u_rnd (
    .clk    (clk),
    .en     (en_i.rnd),
    .rate_i (1'b0),
    .sum_i  (sum_r),
    .res_r  (rb),
    .sat_r  (sb)
  );

  always_comb begin
    res_o = ra8_r;
    sat_o = sa8_r;
    if (mode8_r == MODE_ROT) begin
      for (int k = 0; k < NUM_RES; k++) begin
        res_o[k] = '0;
      end
      for (int k = 0; k < NUM_VEC; k++) begin
        res_o[k] = rb[k];
      end
      // clipping in the intermediate product counts as well
      sat_o = sa8_r | sb;
    end
  end

  assign mode_o = mode8_r;

endmodule

// ----- sv/quaternion_product_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_product_rotate_unit: 8 register stages; an accepted item's result is
// valid once it reaches the last of them; one item per cycle while out_stall is low.
// Two passes of multiply, multiply, sum and round stages; every stage holds.
// Reset (synchronous, rst_n low) empties the pipeline; data is not cleared.
// ----------------------------------------------------------------------------
`include "quaternion_product_rotate_unit_macros.svh"

module quaternion_product_rotate_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_a_w,
  input  logic signed [DATA_WIDTH-1:0] in_a_x,
  input  logic signed [DATA_WIDTH-1:0] in_a_y,
  input  logic signed [DATA_WIDTH-1:0] in_a_z,
  input  logic signed [DATA_WIDTH-1:0] in_b_w,
  input  logic signed [DATA_WIDTH-1:0] in_b_x,
  input  logic signed [DATA_WIDTH-1:0] in_b_y,
  input  logic signed [DATA_WIDTH-1:0] in_b_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_res_0,
  output logic signed [DATA_WIDTH-1:0] out_res_1,
  output logic signed [DATA_WIDTH-1:0] out_res_2,
  output logic signed [DATA_WIDTH-1:0] out_res_3,
  output logic signed [DATA_WIDTH-1:0] out_res_4,
  output logic signed [DATA_WIDTH-1:0] out_res_5,
  output logic signed [DATA_WIDTH-1:0] out_res_6,
  output logic signed [DATA_WIDTH-1:0] out_res_7,
  output logic signed [DATA_WIDTH-1:0] out_res_8,
  output logic                         out_saturated
);

  import qpr_pkg::*;

  localparam int SUM_W   = (2*FRAC_BITS + 2 > 2*DATA_WIDTH + 3) ?
                           2*FRAC_BITS + 2 : 2*DATA_WIDTH + 3;
  localparam int NUM_STG = 2 * PASS_STG;

  logic [NUM_STG-1:0]           vld_r, vld_nxt;
  logic [NUM_STG:0]             rdy;
  qpr_stg_en_t                  en_a, en_b;
  logic signed [DATA_WIDTH-1:0] a_in [NUM_Q];
  logic signed [DATA_WIDTH-1:0] b_in [NUM_Q];
  qpr_mode_t                    mode_ab;
  logic signed [DATA_WIDTH-1:0] a_ab [NUM_Q];
  logic signed [DATA_WIDTH-1:0] res_ab [NUM_RES];
  logic                         sat_ab;
  qpr_mode_t                    out_mode;
  logic signed [DATA_WIDTH-1:0] res [NUM_RES];

  // a stage takes new data when it is empty or its successor moves on
  always_comb begin
    rdy[NUM_STG] = !out_stall;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STG-1];

  assign en_a = '{mul1: rdy[0], mul2: rdy[1], sum: rdy[2], rnd: rdy[3]};
  assign en_b = '{mul1: rdy[4], mul2: rdy[5], sum: rdy[6], rnd: rdy[7]};

  assign a_in[0] = in_a_w;
  assign a_in[1] = in_a_x;
  assign a_in[2] = in_a_y;
  assign a_in[3] = in_a_z;
  assign b_in[0] = in_b_w;
  assign b_in[1] = in_b_x;
  assign b_in[2] = in_b_y;
  assign b_in[3] = in_b_z;

  qpr_pass_a #(.DW(DATA_WIDTH), .F(FRAC_BITS), .SW(SUM_W)) u_pass_a (
    .clk    (clk),
    .en_i   (en_a),
    .mode_i (qpr_mode_t'(in_mode)),
    .a_i    (a_in),
    .b_i    (b_in),
    .mode_o (mode_ab),
    .a_o    (a_ab),
    .res_o  (res_ab),
    .sat_o  (sat_ab)
  );

  qpr_pass_b #(.DW(DATA_WIDTH), .F(FRAC_BITS), .SW(SUM_W)) u_pass_b (
    .clk    (clk),
    .en_i   (en_b),
    .mode_i (mode_ab),
    .a_i    (a_ab),
    .ra_i   (res_ab),
    .sa_i   (sat_ab),
    .mode_o (out_mode),
    .res_o  (res),
    .sat_o  (out_saturated)
  );

  assign out_res_0 = res[0];
  assign out_res_1 = res[1];
  assign out_res_2 = res[2];
  assign out_res_3 = res[3];
  assign out_res_4 = res[4];
  assign out_res_5 = res[5];
  assign out_res_6 = res[6];
  assign out_res_7 = res[7];
  assign out_res_8 = res[8];

  `QPR_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, vld_r[0], "accepted item lost at entry")
  `QPR_ASSERT(a_stall_only_full, clk, rst_n, in_stall, &vld_r, "input stalled while a stage is free")
  `QPR_ASSERT(a_tail_zero, clk, rst_n, out_valid && out_mode != MODE_MAT, out_res_4 == '0 && out_res_5 == '0 && out_res_6 == '0 && out_res_7 == '0 && out_res_8 == '0, "matrix-only results nonzero")
  `QPR_ASSERT(a_rot_w_zero, clk, rst_n, out_valid && out_mode == MODE_ROT, out_res_3 == '0, "rotated vector has a fourth element")

endmodule
